// ----- src/gfrc_pkg.sv -----
package gfrc_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int MAP_W        = 8 * SENSOR_COUNT;
    localparam int ADDR_W       = 32;
    localparam int DATA_W       = 64;
    localparam int CRC_W        = 32;
    localparam int PAGE_W       = 7;
    localparam int INTERVAL_W   = 16;
    localparam int CFG_ADDR_W   = 2;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_SAVE    = 2'd1;
    localparam logic [1:0] CMD_OUTCOME = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_ERASE   = 2'd1;
    localparam logic [1:0] KIND_PROGRAM = 2'd2;

    // status codes
    localparam logic [3:0] ST_SLOT_OK  = 4'd0;
    localparam logic [3:0] ST_SLOT_BAD = 4'd1;
    localparam logic [3:0] ST_SKIP     = 4'd2;
    localparam logic [3:0] ST_RATE     = 4'd3;
    localparam logic [3:0] ST_BUSY     = 4'd4;
    localparam logic [3:0] ST_COMMIT   = 4'd5;
    localparam logic [3:0] ST_FAIL     = 4'd6;
    localparam logic [3:0] ST_STRAY    = 4'd7;
    localparam logic [3:0] ST_ISSUED   = 4'd8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAGE_NUMBER  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RECORD_BASE  = 2'd2;

    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd1000;
    localparam logic [PAGE_W-1:0]     PAGE_NUMBER_RST  = 7'd125;
    localparam logic [ADDR_W-1:0]     RECORD_BASE_RST  = 32'h0807_D000;

    localparam logic [31:0]    REC_MAGIC = 32'h534D_4150;
    localparam logic [7:0]     REC_FLAG  = 8'hA5;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [MAP_W-1:0] MAP_RST = 40'h04_0302_0100;

    // record image covered by the CRC: magic, map, flag, spare
    localparam int REC_BITS      = 96;
    localparam int MAP_LSB       = 32;
    localparam int SPARE_LSB     = 80;
    localparam int CRC_DATA_BITS = MAP_W + 16;

    typedef logic [3:0] status_t;
    typedef logic [CRC_W-1:0] crc_cols_t [CRC_DATA_BITS];

    typedef struct packed {
        logic [1:0]            cmd;
        logic [31:0]           now_ms;
        logic [MAP_W-1:0]      map_packed;
        logic [31:0]           slot_magic;
        logic [7:0]            slot_flag;
        logic [15:0]           slot_spare;
        logic [CRC_W-1:0]      slot_checksum;
        logic                  flash_ok;
    } item_t;

    typedef struct packed {
        logic                  issue;
        status_t               status;
        logic [MAP_W-1:0]      map;
        logic [CRC_W-1:0]      crc;
        logic [MAP_W-1:0]      active_map;
        logic                  map_valid;
    } res_t;

    // bit-serial reflected CRC, elaboration use only
    function automatic logic [CRC_W-1:0] crc_stream(input logic [REC_BITS-1:0] stream,
                                                    input logic [CRC_W-1:0] init);
        logic [CRC_W-1:0] c;
        c = init;
        for (int b = 0; b < REC_BITS; b++) begin
            c[0] = c[0] ^ stream[b];
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC is linear in the data: one column per variable bit, zero init
    function automatic crc_cols_t crc_columns();
        crc_cols_t        cols;
        logic [REC_BITS-1:0] s;
        for (int j = 0; j < CRC_DATA_BITS; j++) begin
            s = '0;
            if (j < MAP_W)
                s[MAP_LSB + j] = 1'b1;
            else
                s[SPARE_LSB + j - MAP_W] = 1'b1;
            cols[j] = crc_stream(s, '0);
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_columns();
    localparam logic [CRC_W-1:0] CRC_BASE =
        crc_stream({16'h0000, REC_FLAG, {MAP_W{1'b0}}, REC_MAGIC}, CRC_INIT) ^ CRC_INIT;

endpackage

// ----- src/gfrc_req_if.sv -----
interface gfrc_req_if import gfrc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [31:0]           now_ms;
    logic [MAP_W-1:0]      map_packed;
    logic [31:0]           slot_magic;
    logic [7:0]            slot_flag;
    logic [15:0]           slot_spare;
    logic [CRC_W-1:0]      slot_checksum;
    logic                  flash_ok;

    modport source (
        output valid, cmd, now_ms, map_packed, slot_magic, slot_flag, slot_spare,
               slot_checksum, flash_ok,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_ms, map_packed, slot_magic, slot_flag, slot_spare,
               slot_checksum, flash_ok,
        output ready
    );
endinterface

// ----- src/gfrc_rsp_if.sv -----
interface gfrc_rsp_if import gfrc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [3:0]            status;
    logic [ADDR_W-1:0]     flash_address;
    logic [DATA_W-1:0]     flash_data;
    logic                  last;
    logic [MAP_W-1:0]      active_map;
    logic                  map_valid;

    modport source (
        output valid, kind, status, flash_address, flash_data, last, active_map, map_valid,
        input  ready
    );
    modport sink (
        input  valid, kind, status, flash_address, flash_data, last, active_map, map_valid,
        output ready
    );
endinterface

// ----- src/gfrc_cfg_if.sv -----
interface gfrc_cfg_if import gfrc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/guarded_flash_record_commit.sv -----
// Guarded flash record commit.
// Channels: req (sink) carries load / save / flash-outcome items, rsp
// (source) carries result items, cfg (sink) writes min_interval_ms (0),
// page_number (1) and record_base_address (2); cfg is always ready.
// A transfer is valid && ready high at a rising clk edge.
// An item waits in the input register, then is decided and loaded into
// the result register, which drives its first result. Load, rejected
// saves and outcomes give one result, an issued save gives erase + two
// programs (last set on the third). Throughput is one item per cycle for
// single-result items while rsp is not stalled; an issued save holds the
// single result register until its last program is taken, one flash request
// per cycle while rsp.ready is high. Command code 3 gives no result.
// Reset (rst_n low, async) restores the identity map, clears the valid,
// pending and written flags and loads the configuration defaults.
// While rsp is stalled the result register holds; one more item waits in
// the input register, then req.ready drops.
module guarded_flash_record_commit import gfrc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    gfrc_req_if.sink   req,
    gfrc_rsp_if.source rsp,
    gfrc_cfg_if.sink   cfg
);

    logic [INTERVAL_W-1:0] min_interval_reg;
    logic [PAGE_W-1:0]     page_number_reg;
    logic [ADDR_W-1:0]     record_base_reg;

    logic  item_valid_reg;
    item_t item_reg;
    logic  fire;
    logic  can_load;
    logic  has_result;
    res_t  res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_interval_reg <= MIN_INTERVAL_RST;
            page_number_reg  <= PAGE_NUMBER_RST;
            record_base_reg  <= RECORD_BASE_RST;
        end else if (cfg.valid) begin
            unique case (cfg.addr)
                REG_MIN_INTERVAL: min_interval_reg <= cfg.data[INTERVAL_W-1:0];
                REG_PAGE_NUMBER:  page_number_reg  <= cfg.data[PAGE_W-1:0];
                REG_RECORD_BASE:  record_base_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign fire      = item_valid_reg && can_load;
    assign req.ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (req.ready)
            item_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            item_reg.cmd           <= req.cmd;
            item_reg.now_ms        <= req.now_ms;
            item_reg.map_packed    <= req.map_packed;
            item_reg.slot_magic    <= req.slot_magic;
            item_reg.slot_flag     <= req.slot_flag;
            item_reg.slot_spare    <= req.slot_spare;
            item_reg.slot_checksum <= req.slot_checksum;
            item_reg.flash_ok      <= req.flash_ok;
        end
    end

    gfrc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .item            (item_reg),
        .min_interval_ms (min_interval_reg),
        .res             (res),
        .has_result      (has_result)
    );

    gfrc_seq u_seq (
        .clk                 (clk),
        .rst_n               (rst_n),
        .load                (fire && has_result),
        .res_in              (res),
        .page_number         (page_number_reg),
        .record_base_address (record_base_reg),
        .can_load            (can_load),
        .rsp                 (rsp)
    );

endmodule

// ----- src/gfrc_crc.sv -----
module gfrc_crc import gfrc_pkg::*; (
    input  logic [MAP_W-1:0] map,
    input  logic [15:0]      spare,
    output logic [CRC_W-1:0] crc
);

    logic [CRC_DATA_BITS-1:0] bits;

    assign bits = {spare, map};

    // magic and flag are folded into CRC_BASE; a record with any other
    // magic or flag is rejected before its CRC matters
    always_comb
    begin
        crc = CRC_BASE;
        for (int j = 0; j < CRC_DATA_BITS; j++) begin
            if (bits[j])
                crc = crc ^ CRC_COLS[j];
        end
    end

endmodule

// ----- src/gfrc_ctrl.sv -----
module gfrc_ctrl import gfrc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  item_t                 item,
    input  logic [INTERVAL_W-1:0] min_interval_ms,
    output res_t                  res,
    output logic                  has_result
);

    logic [MAP_W-1:0] current_map_reg, current_map_next;
    logic             record_valid_reg, record_valid_next;
    logic             written_once_reg, written_once_next;
    logic [31:0]      last_write_ms_reg, last_write_ms_next;
    logic             write_pending_reg, write_pending_next;
    logic [MAP_W-1:0] pending_map_reg, pending_map_next;

    logic [15:0]      crc_spare;
    logic [CRC_W-1:0] crc;
    logic [31:0]      elapsed;
    logic             slot_good;

    // a save record carries zero spare bytes
    assign crc_spare = (item.cmd == CMD_SAVE) ? 16'h0000 : item.slot_spare;

    gfrc_crc u_crc (
        .map   (item.map_packed),
        .spare (crc_spare),
        .crc   (crc)
    );

    assign elapsed   = item.now_ms - last_write_ms_reg;
    assign slot_good = (item.slot_magic == REC_MAGIC) && (item.slot_flag == REC_FLAG)
                       && (crc == item.slot_checksum);

    always_comb
    begin
        current_map_next   = current_map_reg;
        record_valid_next  = record_valid_reg;
        written_once_next  = written_once_reg;
        last_write_ms_next = last_write_ms_reg;
        write_pending_next = write_pending_reg;
        pending_map_next   = pending_map_reg;
        has_result         = 1'b1;
        res.issue          = 1'b0;
        res.status         = ST_STRAY;
        res.map            = item.map_packed;
        res.crc            = crc;

        unique case (item.cmd)
            CMD_LOAD:
            begin
                record_valid_next = slot_good;
                if (slot_good)
                    current_map_next = item.map_packed;
                res.status = slot_good ? ST_SLOT_OK : ST_SLOT_BAD;
            end
            CMD_SAVE:
            begin
                if (write_pending_reg)
                    res.status = ST_BUSY;
                else if (record_valid_reg && (item.map_packed == current_map_reg))
                    res.status = ST_SKIP;
                else if (written_once_reg && (elapsed < {16'h0000, min_interval_ms}))
                    res.status = ST_RATE;
                else begin
                    res.status         = ST_ISSUED;
                    res.issue          = 1'b1;
                    write_pending_next = 1'b1;
                    pending_map_next   = item.map_packed;
                end
            end
            CMD_OUTCOME:
            begin
                if (!write_pending_reg)
                    res.status = ST_STRAY;
                else begin
                    write_pending_next = 1'b0;
                    if (item.flash_ok) begin
                        current_map_next   = pending_map_reg;
                        record_valid_next  = 1'b1;
                        written_once_next  = 1'b1;
                        last_write_ms_next = item.now_ms;
                        res.status         = ST_COMMIT;
                    end else begin
                        res.status = ST_FAIL;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase

        res.active_map = current_map_next;
        res.map_valid  = record_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            current_map_reg   <= MAP_RST;
            record_valid_reg  <= 1'b0;
            written_once_reg  <= 1'b0;
            last_write_ms_reg <= '0;
            write_pending_reg <= 1'b0;
        end else if (fire) begin
            current_map_reg   <= current_map_next;
            record_valid_reg  <= record_valid_next;
            written_once_reg  <= written_once_next;
            last_write_ms_reg <= last_write_ms_next;
            write_pending_reg <= write_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            pending_map_reg <= pending_map_next;
    end

    a_pending_from_save: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(write_pending_reg) |-> $past(fire && item.cmd == CMD_SAVE))
        else $error("write pending set without an issued save");

    a_first_write_commits: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(written_once_reg) |-> (record_valid_reg && !write_pending_reg))
        else $error("first write recorded without a commit");

    a_last_ms_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (last_write_ms_reg != $past(last_write_ms_reg)) |->
            $past(fire && item.cmd == CMD_OUTCOME && item.flash_ok))
        else $error("write time changed outside a successful outcome");

endmodule

// ----- src/gfrc_seq.sv -----
module gfrc_seq import gfrc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  res_t              res_in,
    input  logic [PAGE_W-1:0] page_number,
    input  logic [ADDR_W-1:0] record_base_address,
    output logic              can_load,
    gfrc_rsp_if.source        rsp
);

    logic       busy_reg;
    logic [1:0] beat_reg;
    res_t       res_reg;
    logic       xfer;
    logic       last_beat;

    assign last_beat = !res_reg.issue || (beat_reg == 2'd2);
    assign xfer      = rsp.valid && rsp.ready;
    assign can_load  = !busy_reg || (xfer && last_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            beat_reg <= 2'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            beat_reg <= 2'd0;
        end else if (xfer) begin
            if (last_beat)
                busy_reg <= 1'b0;
            else
                beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    // save issues erase, doubleword 0, doubleword 1
    always_comb
    begin
        rsp.kind          = KIND_STATUS;
        rsp.flash_address = '0;
        rsp.flash_data    = '0;
        if (res_reg.issue) begin
            case (beat_reg)
                2'd0:
                begin
                    rsp.kind          = KIND_ERASE;
                    rsp.flash_address = {{(ADDR_W - PAGE_W){1'b0}}, page_number};
                end
                2'd1:
                begin
                    rsp.kind          = KIND_PROGRAM;
                    rsp.flash_address = record_base_address;
                    rsp.flash_data    = {res_reg.map[31:0], REC_MAGIC};
                end
                default:
                begin
                    rsp.kind          = KIND_PROGRAM;
                    rsp.flash_address = record_base_address + 32'd8;
                    rsp.flash_data    = {res_reg.crc, 16'h0000, REC_FLAG,
                                         res_reg.map[MAP_W-1:32]};
                end
            endcase
        end
    end

    assign rsp.valid      = busy_reg;
    assign rsp.status     = res_reg.status;
    assign rsp.last       = last_beat;
    assign rsp.active_map = res_reg.active_map;
    assign rsp.map_valid  = res_reg.map_valid;

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !res_reg.issue) |-> (beat_reg == 2'd0))
        else $error("status-only result past its first beat");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && last_beat && !load) |=> !busy_reg)
        else $error("sequencer still busy after final transfer");

    a_issue_status: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && res_reg.issue) |-> (res_reg.status == ST_ISSUED))
        else $error("flash request with wrong status");

endmodule
